[sv/twss_pkg.sv]
// shared types and constants of the temporal window sum subsample unit
`default_nettype none

package twss_pkg;

  // field widths of the ports
  localparam int FUNC_W     = 2;
  localparam int CH_W       = 6;
  localparam int DATA_W     = 16;
  localparam int FRAME_W    = 16;
  localparam int WLEN_W     = 5;
  localparam int STRIDE_W   = 8;
  localparam int CIU_W      = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // arithmetic
  localparam int GAIN_SHIFT = 12;
  localparam int ACC_W      = 32;
  localparam int SUM_W      = ACC_W + 1;
  localparam int PROD_W     = SUM_W + DATA_W;
  localparam int SHIFT_W    = PROD_W - GAIN_SHIFT;
  localparam int VAL_W      = SHIFT_W + 1;

  localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // command queue between front and back
  localparam int CMD_Q_DEPTH = 4;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_SAMPLE  = 2'd0,
    FUNC_GAIN    = 2'd1,
    FUNC_OFFSET  = 2'd2,
    FUNC_RESTART = 2'd3
  } func_e;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS   = 2'd2;

  typedef struct packed {
    func_e                     op;
    logic [CH_W-1:0]           ch;
    logic signed [DATA_W-1:0]  data;
    logic [WLEN_W-1:0]         slot;
    logic                      do_sub;
    logic                      emit;
    logic                      last;
    logic [FRAME_W-1:0]        frame;
  } twss_cmd_t;

endpackage

`default_nettype wire

[sv/twss_ram.sv]
// generic single-write, single-read ram with registered read data
`default_nettype none

module twss_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                     wdata_i,
  input  wire logic                                 re_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read returns the old contents on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[sv/twss_fifo.sv]
// short command queue between the front and the back
`default_nettype none

module twss_fifo
  import twss_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire twss_cmd_t cmd_i,
  output logic           full_o,
  input  wire logic      pop_i,
  output logic           valid_o,
  output twss_cmd_t      cmd_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  twss_cmd_t        mem_q [DEPTH];
  logic [PW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= cmd_i;
    end
  end

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rptr_q];

endmodule

`default_nettype wire

[sv/twss_front.sv]
// front end: accepts beats and config writes, keeps the frame counters
`default_nettype none

module twss_front
  import twss_pkg::*;
#(
  parameter int MAX_CHANNELS = 64,
  parameter int MAX_WINDOW   = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [FUNC_W-1:0]      func_i,
  input  wire logic [CH_W-1:0]        channel_i,
  input  wire logic signed [DATA_W-1:0] data_value_i,
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_value_i,
  input  wire logic                   q_full_i,
  output logic                        q_push_o,
  output twss_cmd_t                   q_cmd_o
);

  localparam int WLEN_MAXV = (1 << WLEN_W) - 1;
  localparam int CIU_MAXV  = (1 << CIU_W) - 1;
  localparam logic [WLEN_W-1:0] WIN_CAP =
    WLEN_W'((MAX_WINDOW > WLEN_MAXV) ? WLEN_MAXV : MAX_WINDOW);
  localparam logic [CIU_W-1:0] CH_CAP =
    CIU_W'((MAX_CHANNELS > CIU_MAXV) ? CIU_MAXV : MAX_CHANNELS);

  logic [WLEN_W-1:0]   window_len_q, window_len_d;
  logic [STRIDE_W-1:0] stride_q, stride_d;
  logic [CIU_W-1:0]    ciu_q, ciu_d;
  logic [WLEN_W-1:0]   frames_seen_q, frames_seen_d;
  logic [STRIDE_W-1:0] stride_phase_q, stride_phase_d;
  logic [WLEN_W-1:0]   slot_q, slot_d;
  logic [FRAME_W-1:0]  frame_cnt_q, frame_cnt_d;

  logic                cfg_acc, in_acc;
  func_e               op;
  logic                restart;
  logic                ch_in_use, ch_is_last, full_now, emit;
  logic [WLEN_W:0]     fs_inc, slot_inc;
  logic [STRIDE_W:0]   ph_inc;
  logic [WLEN_W-1:0]   wv;
  logic [STRIDE_W-1:0] sv;
  logic [CIU_W-1:0]    cv;

  assign cfg_ready_o = !q_full_i;
  assign in_ready_o  = !q_full_i && !cfg_valid_i;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign in_acc      = in_valid_i && in_ready_o;
  assign op          = func_e'(func_i);

  assign ch_in_use  = {1'b0, channel_i} < ciu_q;
  assign ch_is_last = {1'b0, channel_i} == (ciu_q - CIU_W'(1));
  assign fs_inc     = {1'b0, frames_seen_q} + (WLEN_W+1)'(1);
  assign slot_inc   = {1'b0, slot_q} + (WLEN_W+1)'(1);
  assign ph_inc     = {1'b0, stride_phase_q} + (STRIDE_W+1)'(1);
  assign full_now   = fs_inc >= {1'b0, window_len_q};
  assign emit       = full_now && (stride_phase_q == '0);

  always_comb begin
    window_len_d   = window_len_q;
    stride_d       = stride_q;
    ciu_d          = ciu_q;
    frames_seen_d  = frames_seen_q;
    stride_phase_d = stride_phase_q;
    slot_d         = slot_q;
    frame_cnt_d    = frame_cnt_q;
    restart        = 1'b0;
    q_push_o       = 1'b0;
    wv             = cfg_value_i[WLEN_W-1:0];
    sv             = cfg_value_i[STRIDE_W-1:0];
    cv             = cfg_value_i[CIU_W-1:0];

    q_cmd_o        = '0;
    q_cmd_o.op     = op;
    q_cmd_o.ch     = channel_i;
    q_cmd_o.data   = data_value_i;
    q_cmd_o.slot   = slot_q;
    q_cmd_o.do_sub = frames_seen_q >= window_len_q;
    q_cmd_o.emit   = emit;
    q_cmd_o.last   = ch_is_last;
    q_cmd_o.frame  = frame_cnt_q;

    if (wv == '0) begin
      wv = WLEN_W'(1);
    end
    if (wv > WIN_CAP) begin
      wv = WIN_CAP;
    end
    if (sv == '0) begin
      sv = STRIDE_W'(1);
    end
    if (cv == '0) begin
      cv = CIU_W'(1);
    end
    if (cv > CH_CAP) begin
      cv = CH_CAP;
    end

    if (cfg_acc) begin
      case (cfg_index_i)
        CFG_WINDOW_LEN: begin
          window_len_d = wv;
          restart      = 1'b1;
        end
        CFG_STRIDE: begin
          stride_d = sv;
          restart  = 1'b1;
        end
        CFG_CHANNELS: begin
          ciu_d   = cv;
          restart = 1'b1;
        end
        default: ;
      endcase
    end else if (in_acc) begin
      case (op)
        FUNC_SAMPLE: begin
          if (ch_in_use) begin
            q_push_o = 1'b1;
            if (ch_is_last) begin
              if (full_now) begin
                if (emit) begin
                  frame_cnt_d = frame_cnt_q + FRAME_W'(1);
                end
                stride_phase_d = (ph_inc >= {1'b0, stride_q}) ? '0 : ph_inc[STRIDE_W-1:0];
              end
              if (frames_seen_q < window_len_q) begin
                frames_seen_d = fs_inc[WLEN_W-1:0];
              end
              slot_d = (slot_inc >= {1'b0, window_len_q}) ? '0 : slot_inc[WLEN_W-1:0];
            end
          end
        end
        FUNC_GAIN, FUNC_OFFSET: begin
          q_push_o = {1'b0, channel_i} < CH_CAP;
        end
        FUNC_RESTART: begin
          restart = 1'b1;
        end
        default: ;
      endcase
    end

    // restart travels down the queue so the back clears its sums in order
    if (restart) begin
      frames_seen_d  = '0;
      stride_phase_d = '0;
      slot_d         = '0;
      frame_cnt_d    = '0;
      q_push_o       = 1'b1;
      q_cmd_o.op     = FUNC_RESTART;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_len_q   <= WLEN_W'(2);
      stride_q       <= STRIDE_W'(2);
      ciu_q          <= CIU_W'(1);
      frames_seen_q  <= '0;
      stride_phase_q <= '0;
      slot_q         <= '0;
      frame_cnt_q    <= '0;
    end else begin
      window_len_q   <= window_len_d;
      stride_q       <= stride_d;
      ciu_q          <= ciu_d;
      frames_seen_q  <= frames_seen_d;
      stride_phase_q <= stride_phase_d;
      slot_q         <= slot_d;
      frame_cnt_q    <= frame_cnt_d;
    end
  end

endmodule

`default_nettype wire

[sv/twss_back.sv]
// back end: running sum update, gain multiply, bias add and saturation
`default_nettype none

module twss_back
  import twss_pkg::*;
#(
  parameter int MAX_CHANNELS = 64,
  parameter int MAX_WINDOW   = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     q_valid_i,
  input  wire twss_cmd_t                q_cmd_i,
  output logic                          q_pop_o,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic [CH_W-1:0]               out_channel_o,
  output logic [FRAME_W-1:0]            out_frame_o,
  output logic signed [DATA_W-1:0]      out_value_o,
  output logic                          saturated_o,
  output logic                          last_of_frame_o
);

  localparam int CIDX_W     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int HIST_DEPTH = MAX_CHANNELS * MAX_WINDOW;
  localparam int HAW        = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;

  logic                  adv, pop;
  logic [CIDX_W-1:0]     cidx;
  logic [WLEN_W-1:0]     slot_m;
  logic [HAW-1:0]        haddr;

  logic [ACC_W-1:0]      sum_rdata;
  logic [DATA_W-1:0]     hist_rdata, gain_rdata, offs_rdata;

  // stage 1: ram read data arrives
  logic                  p1_vld_q;
  twss_cmd_t             p1_cmd_q;
  logic [CIDX_W-1:0]     p1_cidx_q;
  logic                  p1_gvld_q, p1_ovld_q;

  // stage 2: new sum, gain, offset
  logic                  p2_vld_q;
  logic [SUM_W-1:0]      p2_sum_q;
  logic [DATA_W-1:0]     p2_gain_q, p2_offs_q;
  logic [CH_W-1:0]       p2_ch_q;
  logic [FRAME_W-1:0]    p2_frame_q;
  logic                  p2_last_q;

  // stage 3: product
  logic                  p3_vld_q;
  logic [PROD_W-1:0]     p3_prod_q;
  logic [DATA_W-1:0]     p3_offs_q;
  logic [CH_W-1:0]       p3_ch_q;
  logic [FRAME_W-1:0]    p3_frame_q;
  logic                  p3_last_q;

  // output register
  logic                  out_vld_q;
  logic [CH_W-1:0]       out_ch_q;
  logic [FRAME_W-1:0]    out_frame_q;
  logic [DATA_W-1:0]     out_val_q;
  logic                  out_sat_q, out_last_q;

  // valid bits stand in for the zero reset of the per-channel stores
  logic [MAX_CHANNELS-1:0] svld_q, gvld_q, ovld_q;

  // last running sum written, covers the read that overlapped the write
  logic                  byp_vld_q;
  logic [CIDX_W-1:0]     byp_idx_q;
  logic [ACC_W-1:0]      byp_sum_q;

  logic                  s2_sample, s2_restart, s2_wr;
  logic [ACC_W-1:0]      rs_old;
  logic [SUM_W-1:0]      sum_new;
  logic [PROD_W-1:0]     prod;
  logic [SHIFT_W-1:0]    shifted;
  logic [VAL_W-1:0]      val;
  logic                  fits;
  logic [DATA_W-1:0]     val_sat;

  assign adv     = !out_vld_q || out_ready_i;
  assign pop     = adv && q_valid_i;
  assign q_pop_o = pop;

  assign cidx   = CIDX_W'(q_cmd_i.ch);
  assign slot_m = (32'(q_cmd_i.slot) >= 32'(MAX_WINDOW))
                ? q_cmd_i.slot - WLEN_W'(MAX_WINDOW) : q_cmd_i.slot;
  assign haddr  = HAW'(cidx) * HAW'(MAX_WINDOW) + HAW'(slot_m);

  twss_ram #(.WIDTH(ACC_W), .DEPTH(MAX_CHANNELS)) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (s2_wr),
    .waddr_i (p1_cidx_q),
    .wdata_i (sum_new[ACC_W-1:0]),
    .re_i    (pop),
    .raddr_i (cidx),
    .rdata_o (sum_rdata)
  );

  // history is written with the sample at the read; the read sees the old entry
  twss_ram #(.WIDTH(DATA_W), .DEPTH(HIST_DEPTH)) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (pop && (q_cmd_i.op == FUNC_SAMPLE)),
    .waddr_i (haddr),
    .wdata_i (q_cmd_i.data),
    .re_i    (pop),
    .raddr_i (haddr),
    .rdata_o (hist_rdata)
  );

  twss_ram #(.WIDTH(DATA_W), .DEPTH(MAX_CHANNELS)) u_gain_ram (
    .clk_i   (clk_i),
    .we_i    (pop && (q_cmd_i.op == FUNC_GAIN)),
    .waddr_i (cidx),
    .wdata_i (q_cmd_i.data),
    .re_i    (pop),
    .raddr_i (cidx),
    .rdata_o (gain_rdata)
  );

  twss_ram #(.WIDTH(DATA_W), .DEPTH(MAX_CHANNELS)) u_offs_ram (
    .clk_i   (clk_i),
    .we_i    (pop && (q_cmd_i.op == FUNC_OFFSET)),
    .waddr_i (cidx),
    .wdata_i (q_cmd_i.data),
    .re_i    (pop),
    .raddr_i (cidx),
    .rdata_o (offs_rdata)
  );

  assign s2_sample  = p1_vld_q && (p1_cmd_q.op == FUNC_SAMPLE);
  assign s2_restart = p1_vld_q && (p1_cmd_q.op == FUNC_RESTART);
  assign s2_wr      = adv && s2_sample;

  always_comb begin
    if (byp_vld_q && (byp_idx_q == p1_cidx_q)) begin
      rs_old = byp_sum_q;
    end else if (svld_q[p1_cidx_q]) begin
      rs_old = sum_rdata;
    end else begin
      rs_old = '0;
    end
    sum_new = {{(SUM_W-ACC_W){rs_old[ACC_W-1]}}, rs_old}
            - (p1_cmd_q.do_sub ? {{(SUM_W-DATA_W){hist_rdata[DATA_W-1]}}, hist_rdata}
                               : SUM_W'(0))
            + {{(SUM_W-DATA_W){p1_cmd_q.data[DATA_W-1]}}, p1_cmd_q.data};
  end

  assign prod = $signed({{DATA_W{p2_sum_q[SUM_W-1]}}, p2_sum_q})
              * $signed({{SUM_W{p2_gain_q[DATA_W-1]}}, p2_gain_q});

  // floor shift, offset add, clip to the sample range
  assign shifted = p3_prod_q[PROD_W-1:GAIN_SHIFT];
  assign val     = {shifted[SHIFT_W-1], shifted}
                 + {{(VAL_W-DATA_W){p3_offs_q[DATA_W-1]}}, p3_offs_q};
  assign fits    = (&val[VAL_W-1:DATA_W-1]) || !(|val[VAL_W-1:DATA_W-1]);
  assign val_sat = fits ? val[DATA_W-1:0] : (val[VAL_W-1] ? VAL_MIN : VAL_MAX);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q  <= 1'b0;
      p2_vld_q  <= 1'b0;
      p3_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      byp_vld_q <= 1'b0;
      svld_q    <= '0;
      gvld_q    <= '0;
      ovld_q    <= '0;
    end else if (adv) begin
      p1_vld_q  <= pop;
      p2_vld_q  <= s2_sample && p1_cmd_q.emit;
      p3_vld_q  <= p2_vld_q;
      out_vld_q <= p3_vld_q;
      if (pop && (q_cmd_i.op == FUNC_GAIN)) begin
        gvld_q[cidx] <= 1'b1;
      end
      if (pop && (q_cmd_i.op == FUNC_OFFSET)) begin
        ovld_q[cidx] <= 1'b1;
      end
      if (s2_sample) begin
        svld_q[p1_cidx_q] <= 1'b1;
        byp_vld_q         <= 1'b1;
      end else if (s2_restart) begin
        svld_q    <= '0;
        byp_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (pop) begin
        p1_cmd_q  <= q_cmd_i;
        p1_cidx_q <= cidx;
        p1_gvld_q <= gvld_q[cidx];
        p1_ovld_q <= ovld_q[cidx];
      end
      if (s2_sample) begin
        byp_idx_q  <= p1_cidx_q;
        byp_sum_q  <= sum_new[ACC_W-1:0];
        p2_sum_q   <= sum_new;
        p2_gain_q  <= p1_gvld_q ? gain_rdata : '0;
        p2_offs_q  <= p1_ovld_q ? offs_rdata : '0;
        p2_ch_q    <= p1_cmd_q.ch;
        p2_frame_q <= p1_cmd_q.frame;
        p2_last_q  <= p1_cmd_q.last;
      end
      if (p2_vld_q) begin
        p3_prod_q  <= prod;
        p3_offs_q  <= p2_offs_q;
        p3_ch_q    <= p2_ch_q;
        p3_frame_q <= p2_frame_q;
        p3_last_q  <= p2_last_q;
      end
      if (p3_vld_q) begin
        out_ch_q    <= p3_ch_q;
        out_frame_q <= p3_frame_q;
        out_val_q   <= val_sat;
        out_sat_q   <= !fits;
        out_last_q  <= p3_last_q;
      end
    end
  end

  assign out_valid_o     = out_vld_q;
  assign out_channel_o   = out_ch_q;
  assign out_frame_o     = out_frame_q;
  assign out_value_o     = out_val_q;
  assign saturated_o     = out_sat_q;
  assign last_of_frame_o = out_last_q;

endmodule

`default_nettype wire

[sv/temporal_window_sum_subsample_unit.sv]
// top level: strided window sum decimator with per-channel gain and bias
// path: queue, ram read, new sum and product registers, then the output register
// throughput: one beat per unstalled cycle, set by the single running sum ram port pair
// config writes: one per unstalled cycle; used indexes queue a restart behind old beats
// reset: counters, running sums, gains and offsets read as zero at once (valid bits)
// the sample history ram is not cleared and has no clearing pass
`default_nettype none

module temporal_window_sum_subsample_unit
  import twss_pkg::*;
#(
  parameter int MAX_CHANNELS = 64,
  parameter int MAX_WINDOW   = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,

  // item channel
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic [FUNC_W-1:0]        func_i,
  input  wire logic [CH_W-1:0]          channel_i,
  input  wire logic signed [DATA_W-1:0] data_value_i,

  // configuration write channel
  input  wire logic                     cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]    cfg_value_i,

  // result channel
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic [CH_W-1:0]               out_channel_o,
  output logic [FRAME_W-1:0]            out_frame_o,
  output logic signed [DATA_W-1:0]      out_value_o,
  output logic                          saturated_o,
  output logic                          last_of_frame_o
);

  // queue between front and back: each side stalls on its own
  logic       q_push;
  twss_cmd_t  q_cmd_in;
  logic       q_full;
  logic       q_valid;
  twss_cmd_t  q_head;
  logic       q_pop;

  // front: classifies beats, owns the frame, stride and slot counters,
  // and decides per sample whether it emits and whether the oldest
  // history entry leaves the window
  twss_front #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_WINDOW   (MAX_WINDOW)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .channel_i    (channel_i),
    .data_value_i (data_value_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_value_i  (cfg_value_i),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_cmd_o      (q_cmd_in)
  );

  twss_fifo #(
    .DEPTH (CMD_Q_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_cmd_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (q_head)
  );

  // back: ram reads, running sum read-modify-write with a one-deep
  // bypass, registered multiply, then shift, bias add and clip into
  // the output register
  twss_back #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_WINDOW   (MAX_WINDOW)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_cmd_i         (q_head),
    .q_pop_o         (q_pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_channel_o   (out_channel_o),
    .out_frame_o     (out_frame_o),
    .out_value_o     (out_value_o),
    .saturated_o     (saturated_o),
    .last_of_frame_o (last_of_frame_o)
  );

`ifndef NO_ASSERTIONS
  // the front never pushes into a full queue
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("command pushed into a full queue");

  // the back only pops a queue that holds a command
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("command popped from an empty queue");

  // a clipped result sits on one of the rails
  a_sat_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && saturated_o) |-> (out_value_o == VAL_MAX || out_value_o == VAL_MIN))
    else $error("saturated result not at a rail");
`endif

endmodule

`default_nettype wire

[dv/temporal_window_sum_subsample_unit_tb.sv]
// self-checking testbench of the temporal window sum subsample unit
localparam int NUM_CH     = 64;
localparam int WIN_MAX    = 16;
localparam int HIST_SLOTS = NUM_CH * WIN_MAX;

class window_sum_scoreboard;
  typedef struct packed {
    logic [twss_pkg::CH_W-1:0]           ch;
    logic [twss_pkg::FRAME_W-1:0]        frame;
    logic signed [twss_pkg::DATA_W-1:0]  value;
    logic                                sat;
    logic                                last;
  } window_out_t;

  int unsigned win_len, stride_len, ch_count;
  logic signed [15:0] history [HIST_SLOTS];
  bit                 history_written [HIST_SLOTS];
  int                 sums [NUM_CH];
  logic signed [15:0] gains [NUM_CH];
  logic signed [15:0] offsets [NUM_CH];
  int unsigned        frames_seen, stride_phase, slot;
  logic [15:0]        frame_no;
  window_out_t        pending_outputs [$];
  int unsigned        errors;

  function new();
    win_len    = 2;
    stride_len = 2;
    ch_count   = 1;
    errors     = 0;
    foreach (history[i]) begin
      history[i]         = '0;
      history_written[i] = 1'b0;
    end
    foreach (gains[i]) begin
      gains[i]   = '0;
      offsets[i] = '0;
    end
    restart_sequence();
  endfunction

  function void restart_sequence();
    foreach (sums[i]) sums[i] = 0;
    frames_seen  = 0;
    stride_phase = 0;
    slot         = 0;
    frame_no     = '0;
  endfunction

  // clamp as the block does, then restart; unused index leaves everything alone
  function void apply_config(logic [1:0] idx, logic [7:0] value);
    int unsigned v;
    case (idx)
      twss_pkg::CFG_WINDOW_LEN: begin
        v = value & 8'h1f;
        if (v < 1) v = 1;
        if (v > WIN_MAX) v = WIN_MAX;
        win_len = v;
      end
      twss_pkg::CFG_STRIDE: begin
        v = value;
        if (v < 1) v = 1;
        stride_len = v;
      end
      twss_pkg::CFG_CHANNELS: begin
        v = value & 8'h7f;
        if (v < 1) v = 1;
        if (v > NUM_CH) v = NUM_CH;
        ch_count = v;
      end
      default: return;
    endcase
    restart_sequence();
  endfunction

  // a sample here would subtract a delay line entry never written since reset
  function bit would_read_unwritten(logic [5:0] ch);
    return ch < ch_count && frames_seen >= win_len &&
           !history_written[ch * WIN_MAX + slot % WIN_MAX];
  endfunction

  function void take_beat(twss_pkg::func_e op, logic [5:0] ch, logic signed [15:0] data);
    int unsigned idx;
    longint      acc, prod, val;
    bit          full_now, emit, last;
    window_out_t r;
    case (op)
      twss_pkg::FUNC_GAIN:    gains[ch] = data;
      twss_pkg::FUNC_OFFSET:  offsets[ch] = data;
      twss_pkg::FUNC_RESTART: restart_sequence();
      default: begin
        if (ch >= ch_count) return;
        idx = ch * WIN_MAX + slot % WIN_MAX;
        acc = sums[ch];
        if (frames_seen >= win_len) acc -= history[idx];
        acc += data;
        history[idx]         = data;
        history_written[idx] = 1'b1;
        sums[ch]             = int'(acc);
        full_now = (frames_seen + 1 >= win_len);
        emit     = full_now && stride_phase == 0;
        last     = (ch == ch_count - 1);
        if (emit) begin
          prod  = acc * longint'(gains[ch]);
          val   = (prod >>> 12) + longint'(offsets[ch]);
          r.sat = 1'b0;
          if (val > 32767) begin
            val   = 32767;
            r.sat = 1'b1;
          end
          if (val < -32768) begin
            val   = -32768;
            r.sat = 1'b1;
          end
          r.ch    = ch;
          r.frame = frame_no;
          r.value = val[15:0];
          r.last  = last;
          pending_outputs.push_back(r);
        end
        if (last) begin
          if (full_now) begin
            if (emit) frame_no = frame_no + 16'd1;
            stride_phase = (stride_phase + 1 >= stride_len) ? 0 : stride_phase + 1;
          end
          if (frames_seen < win_len) frames_seen++;
          slot = (slot + 1 >= win_len) ? 0 : slot + 1;
        end
      end
    endcase
  endfunction

  function void check_output(window_out_t got);
    window_out_t want;
    if (pending_outputs.size() == 0) begin
      errors++;
      $display("%0t: output with none expected: ch %0d frame %0d value %0d sat %0b last %0b",
               $time, got.ch, got.frame, got.value, got.sat, got.last);
      return;
    end
    want = pending_outputs.pop_front();
    if (got !== want) begin
      errors++;
      $display("%0t: mismatch expected ch %0d frame %0d value %0d sat %0b last %0b",
               $time, want.ch, want.frame, want.value, want.sat, want.last);
      $display("%0t:          actual   ch %0d frame %0d value %0d sat %0b last %0b",
               $time, got.ch, got.frame, got.value, got.sat, got.last);
    end
  endfunction
endclass

module temporal_window_sum_subsample_unit_tb
  import twss_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // index past the register list, must be a no-op
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  // cycles with no beat anywhere before the run is declared hung
  localparam int STALL_LIMIT = 4000;
  // settle time after the last result, covers the pipeline
  localparam int DRAIN_CYCLES = 10;
  localparam int BEAT_TARGET  = 1280;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic [FUNC_W-1:0]        func_i = FUNC_SAMPLE;
  logic [CH_W-1:0]          channel_i = '0;
  logic signed [DATA_W-1:0] data_value_i = '0;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [CFG_IDX_W-1:0]     cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]    cfg_value_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic [CH_W-1:0]          out_channel_o;
  logic [FRAME_W-1:0]       out_frame_o;
  logic signed [DATA_W-1:0] out_value_o;
  logic                     saturated_o;
  logic                     last_of_frame_o;

  window_sum_scoreboard sb = new();
  bit          calm = 1'b0;     // no idling on either side while set
  int unsigned beats_sent = 0;
  int unsigned stall_cycles = 0;

  temporal_window_sum_subsample_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .func_i          (func_i),
    .channel_i       (channel_i),
    .data_value_i    (data_value_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_value_i     (cfg_value_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_channel_o   (out_channel_o),
    .out_frame_o     (out_frame_o),
    .out_value_o     (out_value_o),
    .saturated_o     (saturated_o),
    .last_of_frame_o (last_of_frame_o)
  );

  always #5 clk_i = ~clk_i;

  // result side back-pressure, ready low with a chance of roughly 18 in a hundred
  always @(posedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(99) >= 18);
  end

  // result monitor, values sampled before the edge updates them
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_output('{out_channel_o, out_frame_o, out_value_o, saturated_o,
                        last_of_frame_o});
    end
  end

  // hang detection: any beat on any channel restarts the count
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (cfg_valid_i && cfg_ready_o) ||
        (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("[temporal_window_sum_subsample_unit] ERROR");
      $finish;
    end
  end

  // one input beat; samples that would hit an unwritten delay slot are dropped
  task automatic send_beat(func_e op, logic [CH_W-1:0] ch, logic signed [DATA_W-1:0] data);
    if (op == FUNC_SAMPLE && sb.would_read_unwritten(ch)) return;
    if (!calm && $urandom_range(99) < 11) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    func_i       <= op;
    channel_i    <= ch;
    data_value_i <= data;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.take_beat(op, ch, data);
    beats_sent++;
  endtask

  // sender holds off until every predicted result has come out
  task automatic wait_results();
    in_valid_i <= 1'b0;
    while (sb.pending_outputs.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    // ignored beats may still be in flight, so let the pipeline empty too
    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_value_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    sb.apply_config(idx, value);
  endtask

  task automatic configure(logic [7:0] wlen, logic [7:0] stride, logic [7:0] chans);
    write_cfg(CFG_WINDOW_LEN, wlen);
    write_cfg(CFG_STRIDE, stride);
    write_cfg(CFG_CHANNELS, chans);
  endtask

  function automatic logic signed [15:0] rand_sample();
    if ($urandom_range(9) < 6) return 16'($urandom);
    return 16'($urandom_range(1023)) - 16'd512;
  endfunction

  function automatic logic signed [15:0] rand_gain();
    if ($urandom_range(1)) return 16'($urandom);
    return 16'($urandom_range(8191)) - 16'd4096;
  endfunction

  function automatic logic signed [15:0] rand_offset();
    if ($urandom_range(1)) return 16'($urandom);
    return 16'($urandom_range(2047)) - 16'd1024;
  endfunction

  task automatic load_coefficients();
    for (int c = 0; c < sb.ch_count; c++) begin
      send_beat(FUNC_GAIN, CH_W'(c), rand_gain());
      send_beat(FUNC_OFFSET, CH_W'(c), rand_offset());
    end
  endtask

  // stray beat: restart, coefficient write or sample on any channel
  task automatic send_noise();
    int unsigned k;
    logic [CH_W-1:0] ch;
    k  = $urandom_range(99);
    ch = CH_W'($urandom_range(63));
    if (k < 5) send_beat(FUNC_RESTART, ch, rand_sample());
    else if (k < 35) send_beat(FUNC_GAIN, ch, rand_gain());
    else if (k < 65) send_beat(FUNC_OFFSET, ch, rand_offset());
    else send_beat(FUNC_SAMPLE, ch, rand_sample());
  endtask

  // frames of channels in order, with stray beats and skipped samples mixed in
  task automatic run_frames(int unsigned frames, int unsigned noise_pct);
    int unsigned r;
    for (int unsigned f = 0; f < frames; f++) begin
      for (int c = 0; c < sb.ch_count; c++) begin
        r = $urandom_range(99);
        if (r < noise_pct) send_noise();
        if (r >= noise_pct || r % 3 != 0) send_beat(FUNC_SAMPLE, CH_W'(c), rand_sample());
      end
    end
  endtask

  task automatic random_phase();
    logic [7:0]  wlen, stride, chans;
    int unsigned frames;
    wlen   = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(8, 1));
    stride = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(4, 1));
    chans  = ($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(6, 1));
    configure(wlen, stride, chans);
    load_coefficients();
    frames = 72 / sb.ch_count + 2;
    run_frames(frames / 2, 8);
    // hold the sender back until the output side has caught up
    wait_results();
    run_frames(frames - frames / 2, 8);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: window of two, stride two, one channel
    send_beat(FUNC_GAIN, 6'd0, 16'sh7fff);
    send_beat(FUNC_OFFSET, 6'd0, 16'sh7fff);
    send_beat(FUNC_SAMPLE, 6'd0, 16'sh7fff);
    send_beat(FUNC_SAMPLE, 6'd0, 16'sh7fff);   // first window, clips high
    send_beat(FUNC_SAMPLE, 6'd63, 16'sh7fff);  // channel out of use
    send_beat(FUNC_GAIN, 6'd0, 16'sh8000);
    send_beat(FUNC_OFFSET, 6'd0, 16'sh8000);
    send_beat(FUNC_SAMPLE, 6'd0, 16'sh8000);   // skipped by stride
    send_beat(FUNC_SAMPLE, 6'd0, 16'sh8000);   // two negatives, clips high
    send_beat(FUNC_GAIN, 6'd0, 16'sh7fff);
    send_beat(FUNC_SAMPLE, 6'd0, 16'sh8000);
    send_beat(FUNC_SAMPLE, 6'd0, 16'sh8000);   // clips low
    send_beat(FUNC_RESTART, 6'd63, 16'shffff);
    send_beat(FUNC_GAIN, 6'd0, 16'sh0001);
    send_beat(FUNC_OFFSET, 6'd0, 16'sh0000);
    send_beat(FUNC_SAMPLE, 6'd0, 16'shffff);
    send_beat(FUNC_SAMPLE, 6'd0, 16'sh0000);   // tiny negative product floors to -1
    send_beat(FUNC_GAIN, 6'd63, 16'sh5a5a);
    send_beat(FUNC_OFFSET, 6'd63, 16'sha5a5);
    send_beat(FUNC_SAMPLE, 6'd42, 16'sh1234);  // out of use again

    // widest frame, one-frame window, every sample gives a result, no idling
    calm = 1'b1;
    configure(8'd1, 8'd1, 8'd64);
    load_coefficients();
    run_frames(2, 0);
    calm = 1'b0;

    // clamped maxima: window 16, stride 255, channel count clamps to one
    configure(8'hff, 8'd255, 8'd0);
    write_cfg(CFG_UNUSED, 8'($urandom));
    load_coefficients();
    run_frames(20, 5);

    // long window with stride of one, raw zero stride
    configure(8'd16, 8'd0, 8'd3);
    load_coefficients();
    run_frames(30, 5);

    // zero window clamps to one, sparse outputs, channel count clamps to 64 first
    configure(8'd0, 8'd255, 8'hff);
    write_cfg(CFG_CHANNELS, 8'd2);
    load_coefficients();
    run_frames(10, 5);

    while (beats_sent < BEAT_TARGET) random_phase();

    wait_results();
    repeat (2 * DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("[temporal_window_sum_subsample_unit] OK");
    end else begin
      $display("[temporal_window_sum_subsample_unit] ERROR");
    end
    $finish;
  end

endmodule
